[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off during reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  `ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `ASSERT_CLK(lbl, clk, rst_n, (ante) |=> (cons))

`endif

[rtl/core/tcv_pkg.sv]
// ---------------------------------------------------------------------------
// tcv_pkg
// Types, codes and constants of the clause vote classifier.
// ---------------------------------------------------------------------------
package tcv_pkg;

  localparam int IDX_W      = 6;
  localparam int STATE_W    = 16;
  localparam int SPA_W      = 15;
  localparam int THR_W      = 16;
  localparam int FEAT_W     = 32;
  localparam int VOTE_W     = 7;
  localparam int VOTE_LIMIT = 32;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_NUM_CLAUSES  = 64;
  localparam int DEF_NUM_FEATURES = 32;

  localparam logic [SPA_W-1:0] SPA_RESET = 15'd100;
  localparam logic [THR_W-1:0] THR_RESET = 16'd15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_STATES    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOTE_THRESHOLD = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE    = 2'd0,
    CMD_READ     = 2'd1,
    CMD_CLASSIFY = 2'd2
  } tcv_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CLS_RUN,
    ST_CLS_DRAIN,
    ST_FINISH
  } tcv_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the request
    logic rd_clause;  // read the addressed clause row
    logic cls_rd;     // read the row at the clause counter and advance it
    logic finish;     // commit write, load result registers
  } tcv_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_row;
  } tcv_stat_t;

endpackage

[rtl/core/tsetlin_clause_vote_classifier_unit.sv]
// ---------------------------------------------------------------------------
// tsetlin_clause_vote_classifier_unit
// Start accept to result strobe: write or unused goes straight to finish;
//   read reads the row first; classify walks the rows, then drains. Busy
//   drops in the strobe cycle, and a new request is taken once busy is low.
//   Classify reads one clause row per cycle from the single-port memory.
// Reset (rst_ni, async, low) returns to idle with default registers; state
//   memory is not cleared, every entry must be loaded before use.
// ---------------------------------------------------------------------------
module tsetlin_clause_vote_classifier_unit #(
  parameter int NUM_CLAUSES  = tcv_pkg::DEF_NUM_CLAUSES,
  parameter int NUM_FEATURES = tcv_pkg::DEF_NUM_FEATURES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [tcv_pkg::CMD_W-1:0]          command_i,
  input  logic [tcv_pkg::IDX_W-1:0]          clause_index_i,
  input  logic [tcv_pkg::IDX_W-1:0]          literal_index_i,
  input  logic [tcv_pkg::STATE_W-1:0]        state_value_i,
  input  logic [tcv_pkg::FEAT_W-1:0]         feature_bits_i,
  // result channel, one-cycle strobe, cannot be stalled
  output logic                               done_o,
  output logic signed [tcv_pkg::VOTE_W-1:0]  vote_sum_o,
  output logic                               prediction_o,
  output logic [tcv_pkg::STATE_W-1:0]        read_value_o,
  output logic                               status_o,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tcv_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tcv_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import tcv_pkg::*;

  tcv_cmd_t  cmd;
  tcv_stat_t stat;

  // The user must change registers only while idle; the block does not enforce it. Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Sequencer: idle -> (read | classify walk and drain | nothing for write) -> finish -> idle
  tcv_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy_o)
  );

  // Memory rows hold 2*NUM_FEATURES states of one clause; classify
  // evaluates one row per cycle and folds the vote into the accumulator.
  tcv_datapath #(
    .NUM_CLAUSES  (NUM_CLAUSES),
    .NUM_FEATURES (NUM_FEATURES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .command_i       (command_i),
    .clause_index_i  (clause_index_i),
    .literal_index_i (literal_index_i),
    .state_value_i   (state_value_i),
    .feature_bits_i  (feature_bits_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .vote_sum_o      (vote_sum_o),
    .prediction_o    (prediction_o),
    .read_value_o    (read_value_o),
    .status_o        (status_o)
  );

endmodule

[rtl/core/tcv_ctrl.sv]
// ---------------------------------------------------------------------------
// tcv_ctrl
// Sequencer for write, read and classify requests.
// ---------------------------------------------------------------------------
module tcv_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tcv_pkg::CMD_W-1:0] command_i,
  input  tcv_pkg::tcv_stat_t        stat_i,
  output tcv_pkg::tcv_cmd_t         cmd_o,
  output logic                      busy_o
);
  import tcv_pkg::*;

  tcv_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          case (command_i)
            CMD_READ:     state_d = ST_READ;
            CMD_CLASSIFY: state_d = ST_CLS_RUN;
            default:      state_d = ST_FINISH;
          endcase
        end
      end
      ST_READ: begin
        cmd_o.rd_clause = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_CLS_RUN: begin
        cmd_o.cls_rd = 1'b1;
        if (stat_i.last_row) begin
          state_d = ST_CLS_DRAIN;
        end
      end
      ST_CLS_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/tcv_datapath.sv]
// ---------------------------------------------------------------------------
// tcv_datapath
// State memory, clause evaluation, vote accumulator and result registers.
// ---------------------------------------------------------------------------
module tcv_datapath #(
  parameter int NUM_CLAUSES  = tcv_pkg::DEF_NUM_CLAUSES,
  parameter int NUM_FEATURES = tcv_pkg::DEF_NUM_FEATURES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tcv_pkg::tcv_cmd_t              cmd_i,
  output tcv_pkg::tcv_stat_t             stat_o,
  input  logic [tcv_pkg::CMD_W-1:0]      command_i,
  input  logic [tcv_pkg::IDX_W-1:0]      clause_index_i,
  input  logic [tcv_pkg::IDX_W-1:0]      literal_index_i,
  input  logic [tcv_pkg::STATE_W-1:0]    state_value_i,
  input  logic [tcv_pkg::FEAT_W-1:0]     feature_bits_i,
  input  logic                           cfg_we_i,
  input  logic [tcv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tcv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           done_o,
  output logic signed [tcv_pkg::VOTE_W-1:0] vote_sum_o,
  output logic                           prediction_o,
  output logic [tcv_pkg::STATE_W-1:0]    read_value_o,
  output logic                           status_o
);
  import tcv_pkg::*;

  localparam int NUM_LIT = 2 * NUM_FEATURES;
  localparam int CW      = (NUM_CLAUSES > 1) ? $clog2(NUM_CLAUSES) : 1;
  localparam int LW      = (NUM_LIT > 1) ? $clog2(NUM_LIT) : 1;
  localparam int CXW     = (CW > IDX_W) ? CW : IDX_W;
  localparam int LXW     = (LW > IDX_W) ? LW : IDX_W;
  localparam int ACC_W   = $clog2(NUM_CLAUSES / 2 + 1) + 1;
  localparam int CLP_W   = THR_W + 2;

  // Configuration
  logic [SPA_W-1:0] spa_q;
  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spa_q <= SPA_RESET;
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HALF_STATES:    spa_q <= cfg_data_i[SPA_W-1:0];
        CFG_VOTE_THRESHOLD: thr_q <= cfg_data_i[THR_W-1:0];
        default:            ;
      endcase
    end
  end

  // Request capture
  logic [CMD_W-1:0]        cmd_q;
  logic [CW-1:0]           row_q;
  logic [LW-1:0]           lane_q;
  logic [STATE_W-1:0]      val_q;
  logic [NUM_FEATURES-1:0] feat_q, feat_d;
  logic                    addr_ok_q, reject_q;
  logic [CXW-1:0]          clause_wide;
  logic [LXW-1:0]          lit_wide;
  logic                    addr_ok_d, reject_d;

  assign clause_wide = CXW'(clause_index_i);
  assign lit_wide    = LXW'(literal_index_i);
  assign addr_ok_d   = (32'(clause_index_i) < NUM_CLAUSES) &&
                       (32'(literal_index_i) < NUM_LIT);
  assign reject_d    = (state_value_i == '0) ||
                       ({1'b0, state_value_i} > {1'b0, spa_q, 1'b0});

  for (genvar k = 0; k < NUM_FEATURES; k++) begin : g_feat
    if (k < FEAT_W) begin : g_in
      assign feat_d[k] = feature_bits_i[k];
    end else begin : g_zero
      assign feat_d[k] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= command_i;
      row_q     <= clause_wide[CW-1:0];
      lane_q    <= lit_wide[LW-1:0];
      val_q     <= state_value_i;
      feat_q    <= feat_d;
      addr_ok_q <= addr_ok_d;
      reject_q  <= reject_d;
    end
  end

  // Clause counter
  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.cls_rd) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  assign stat_o.last_row = (cnt_q == CW'(NUM_CLAUSES - 1));

  // State memory, one clause row per word, one lane per literal
  logic [NUM_LIT-1:0][STATE_W-1:0] mem_q [NUM_CLAUSES];
  logic [NUM_LIT-1:0][STATE_W-1:0] rd_row_q;
  logic                            mem_we;
  logic                            mem_re;
  logic [CW-1:0]                   rd_addr;

  assign mem_we  = cmd_i.finish && (cmd_q == CMD_WRITE) && !reject_q && addr_ok_q;
  assign mem_re  = cmd_i.rd_clause || cmd_i.cls_rd;
  assign rd_addr = cmd_i.cls_rd ? cnt_q : row_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[row_q][lane_q] <= val_q;
    end
    if (mem_re) begin
      rd_row_q <= mem_q[rd_addr];
    end
  end

  // Clause evaluation on the registered row
  logic [NUM_LIT-1:0] incl, lit_true;
  logic               fires;

  for (genvar l = 0; l < NUM_LIT; l++) begin : g_lit
    assign incl[l] = rd_row_q[l] > {1'b0, spa_q};
    if (l % 2 == 0) begin : g_pos
      assign lit_true[l] = feat_q[l / 2];
    end else begin : g_neg
      assign lit_true[l] = ~feat_q[l / 2];
    end
  end

  assign fires = (|incl) && !(|(incl & ~lit_true));

  // Vote accumulator, one row behind the memory read
  logic                    acc_vld_q;
  logic                    parity_q;
  logic signed [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= 1'b0;
    end else begin
      acc_vld_q <= cmd_i.cls_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cls_rd) begin
      parity_q <= cnt_q[0];
    end
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (acc_vld_q && fires) begin
      acc_q <= parity_q ? acc_q - ACC_W'(1) : acc_q + ACC_W'(1);
    end
  end

  // Clamp to threshold, then to the vote range
  logic signed [CLP_W-1:0] sum_ext, thr_pos, thr_neg, clp_a, clp_b;

  always_comb begin
    sum_ext = CLP_W'(acc_q);
    thr_pos = signed'({2'b00, thr_q});
    thr_neg = -thr_pos;
    clp_a   = sum_ext;
    if (clp_a > thr_pos) clp_a = thr_pos;
    if (clp_a < thr_neg) clp_a = thr_neg;
    clp_b = clp_a;
    if (clp_b > CLP_W'(VOTE_LIMIT))  clp_b = CLP_W'(VOTE_LIMIT);
    if (clp_b < -CLP_W'(VOTE_LIMIT)) clp_b = -CLP_W'(VOTE_LIMIT);
  end

  // Result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      vote_sum_o   <= '0;
      prediction_o <= 1'b0;
      read_value_o <= '0;
      status_o     <= 1'b0;
      case (cmd_q)
        CMD_WRITE: begin
          status_o <= reject_q;
        end
        CMD_READ: begin
          if (addr_ok_q) read_value_o <= rd_row_q[lane_q];
        end
        CMD_CLASSIFY: begin
          vote_sum_o   <= clp_b[VOTE_W-1:0];
          // positive: sign bit clear and not zero
          prediction_o <= !clp_b[CLP_W-1] && (clp_b != '0);
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/tcv_checker.sv]
// ---------------------------------------------------------------------------
// tcv_checker
// Port-level checks on the classifier, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [6:0]  vote_sum_o,
  input logic        prediction_o,
  input logic [15:0] read_value_o,
  input logic        status_o
);

  logic vote_pos, zero_payload;

  assign vote_pos     = !vote_sum_o[6] && (vote_sum_o != 7'd0);
  assign zero_payload = (read_value_o == 16'd0) && (vote_sum_o == 7'd0);

  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `ASSERT_IMPL(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy_o))
  `ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `ASSERT_IMPL(a_pred_positive, clk_i, rst_ni, done_o && prediction_o, vote_pos)
  `ASSERT_IMPL(a_reject_clean, clk_i, rst_ni, done_o && status_o, zero_payload)

endmodule

bind tsetlin_clause_vote_classifier_unit tcv_checker u_checker (.*);
